@@ rtl/pat_pkg.sv @@
// shared types and constants of the page access trace generator
package pat_pkg;

    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;
    localparam int REM_W      = 21;

    localparam logic [63:0] LCG_MUL = 64'h5851_F42D_4C95_7F2D;
    localparam logic [63:0] LCG_ADD = 64'h1405_7B7E_F767_814F;

    localparam logic [REM_W-1:0] PICK_MOD  = 21'd100;
    localparam logic [6:0]       WP_LIMIT  = 7'd100;

    // powers of two modulo 100 and a reciprocal of 100, used to fold the write pick
    localparam logic [63:0] RES_2P16  = 64'd36;
    localparam logic [63:0] RES_2P32  = 64'd96;
    localparam logic [63:0] RES_2P48  = 64'd56;
    localparam logic [63:0] RES_2P10  = 64'd24;
    localparam logic [63:0] RCP_100   = 64'd1311;
    localparam int          RCP_SHIFT = 17;
    localparam logic [63:0] NEG_100   = 64'd0 - 64'd100;

    localparam logic        RST_RANDOM_MODE   = 1'b0;
    localparam logic [20:0] RST_PAGE_TOTAL    = 21'd16;
    localparam logic [31:0] RST_RUN_LENGTH    = 32'd1000;
    localparam logic [63:0] RST_SEED_VALUE    = 64'd1;
    localparam logic [63:0] RST_BASE_ADDR     = 64'd4096;
    localparam logic [6:0]  RST_WRITE_PERCENT = 7'd20;

    typedef enum logic [2:0] {
        REG_RANDOM_MODE   = 3'd0,
        REG_PAGE_TOTAL    = 3'd1,
        REG_RUN_LENGTH    = 3'd2,
        REG_SEED_VALUE    = 3'd3,
        REG_BASE_ADDR     = 3'd4,
        REG_WRITE_PERCENT = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic        random_mode;
        logic [20:0] page_total;
        logic [31:0] run_length;
        logic [63:0] seed_value;
        logic [63:0] base_addr;
        logic [6:0]  write_percent;
    } t_cfg;

    // operands of the shared multiply-accumulate / remainder unit
    typedef struct packed {
        logic [63:0]      acc;
        logic [63:0]      mul_a;
        logic [15:0]      digit;
        logic [1:0]       sel;
        logic [REM_W-1:0] rem;
        logic             rem_bit;
        logic [REM_W-1:0] divisor;
    } t_unit_req;

    typedef struct packed {
        logic [63:0]      acc;
        logic             carry;
        logic [REM_W-1:0] rem;
    } t_unit_rsp;

endpackage

@@ rtl/pat_if.sv @@
// request and access channel interfaces
interface pat_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface pat_acc_if;
    logic        valid;
    logic        ready;
    logic        is_write;
    logic [63:0] access_address;
    logic [31:0] access_number;
    logic        last;
    logic        done_res;
    logic        config_error;

    modport source (output valid, output is_write, output access_address,
                    output access_number, output last, output done_res,
                    output config_error, input ready);
    modport sink   (input valid, input is_write, input access_address,
                    input access_number, input last, input done_res,
                    input config_error, output ready);
endinterface

@@ rtl/pat_cfg_regs.sv @@
// apb configuration register file
module pat_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pat_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pat_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pat_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output pat_pkg::t_cfg                  o_cfg
);
    import pat_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:3]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.random_mode   <= RST_RANDOM_MODE;
            r_cfg.page_total    <= RST_PAGE_TOTAL;
            r_cfg.run_length    <= RST_RUN_LENGTH;
            r_cfg.seed_value    <= RST_SEED_VALUE;
            r_cfg.base_addr     <= RST_BASE_ADDR;
            r_cfg.write_percent <= RST_WRITE_PERCENT;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_RANDOM_MODE:   r_cfg.random_mode   <= pwdata[0];
                REG_PAGE_TOTAL:    r_cfg.page_total    <= pwdata[20:0];
                REG_RUN_LENGTH:    r_cfg.run_length    <= pwdata[31:0];
                REG_SEED_VALUE:    r_cfg.seed_value    <= pwdata;
                REG_BASE_ADDR:     r_cfg.base_addr     <= pwdata;
                REG_WRITE_PERCENT: r_cfg.write_percent <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_RANDOM_MODE:   prdata = {63'b0, r_cfg.random_mode};
            REG_PAGE_TOTAL:    prdata = {43'b0, r_cfg.page_total};
            REG_RUN_LENGTH:    prdata = {32'b0, r_cfg.run_length};
            REG_SEED_VALUE:    prdata = r_cfg.seed_value;
            REG_BASE_ADDR:     prdata = r_cfg.base_addr;
            REG_WRITE_PERCENT: prdata = {57'b0, r_cfg.write_percent};
            default:           prdata = '0;
        endcase
    end

endmodule

@@ rtl/pat_unit.sv @@
// shared 64x16 multiply-accumulate and one-bit remainder step
module pat_unit (
    input  pat_pkg::t_unit_req i_req,
    output pat_pkg::t_unit_rsp o_rsp
);
    import pat_pkg::*;

    logic [63:0]    prod;
    logic [63:0]    shifted;
    logic [64:0]    sum;
    logic [REM_W:0] trial;
    logic [REM_W:0] diff;
    logic           ge;

    // acc + (a * digit) << 16*sel, low 64 bits plus carry out
    assign prod    = i_req.mul_a * {48'b0, i_req.digit};
    assign shifted = prod << {i_req.sel, 4'b0};
    assign sum     = {1'b0, i_req.acc} + {1'b0, shifted};

    // restoring remainder step, one dividend bit
    assign trial = {i_req.rem, i_req.rem_bit};
    assign diff  = trial - {1'b0, i_req.divisor};
    assign ge    = trial >= {1'b0, i_req.divisor};

    assign o_rsp.acc   = sum[63:0];
    assign o_rsp.carry = sum[64];
    assign o_rsp.rem   = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];

endmodule

@@ rtl/pat_seq.sv @@
// sequencer: range check, lcg draws, remainders, address and result register
module pat_seq #(
    parameter int PAGE_BYTES      = 4096,
    parameter int PAGE_COUNT_BITS = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pat_pkg::t_cfg      i_cfg,
    output pat_pkg::t_unit_req o_unit_req,
    input  pat_pkg::t_unit_rsp i_unit_rsp,
    pat_req_if.sink            i_req,
    pat_acc_if.source          o_acc
);
    import pat_pkg::*;

    localparam logic [63:0] PB64 = 64'(PAGE_BYTES);
    localparam logic [32:0] CAP  = 33'd1 << PAGE_COUNT_BITS;

    // steps of the modulo-100 fold of the second draw
    localparam logic [5:0] M100_QUO  = 6'd5;
    localparam logic [5:0] M100_LAST = 6'd6;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK0, S_CHK1, S_DECIDE, S_LCG, S_DIV, S_M100, S_ADR0, S_ADR1, S_OUT
    } t_state;

    t_state           r_state;
    logic [5:0]       r_cnt;
    logic             r_draw2;
    logic [63:0]      r_rng;
    logic [31:0]      r_idx;
    logic [63:0]      r_acc;
    logic [15:0]      r_quo;
    logic             r_ovf;
    logic [63:0]      r_dvd;
    logic [REM_W-1:0] r_rem;
    logic [20:0]      r_page;
    logic             r_wr;
    logic             r_bad;
    logic             r_done;

    logic             r_out_vld;
    logic             r_o_write;
    logic [63:0]      r_o_addr;
    logic [31:0]      r_o_num;
    logic             r_o_last;
    logic             r_o_done;
    logic             r_o_err;

    logic [20:0] pages;
    logic [20:0] pm1;
    logic        bad_cfg;
    logic        out_free;
    logic        normal;
    logic        out_load;

    // page total saturates at 2^PAGE_COUNT_BITS
    assign pages   = ({12'b0, i_cfg.page_total} > CAP) ? CAP[20:0] : i_cfg.page_total;
    assign pm1     = pages - 21'd1;
    assign bad_cfg = (pages == 21'd0) || (i_cfg.run_length == 32'd0) ||
                     (i_cfg.write_percent > WP_LIMIT) || r_ovf;
    assign out_free = !r_out_vld || o_acc.ready;
    assign normal   = !r_bad && !r_done;
    assign out_load = (r_state == S_OUT) && out_free;

    always_comb begin
        o_unit_req.acc     = r_acc;
        o_unit_req.mul_a   = PB64;
        o_unit_req.digit   = '0;
        o_unit_req.sel     = 2'd0;
        o_unit_req.rem     = r_rem;
        o_unit_req.rem_bit = r_dvd[63];
        o_unit_req.divisor = pages;
        unique case (r_state)
            S_CHK0: begin
                o_unit_req.acc   = i_cfg.base_addr;
                o_unit_req.digit = pm1[15:0];
            end
            S_CHK1: begin
                o_unit_req.digit = {11'b0, pm1[20:16]};
                o_unit_req.sel   = 2'd1;
            end
            S_LCG: begin
                o_unit_req.acc   = (r_cnt[1:0] == 2'd0) ? LCG_ADD : r_acc;
                o_unit_req.mul_a = LCG_MUL;
                o_unit_req.digit = r_rng[{r_cnt[1:0], 4'b0} +: 16];
                o_unit_req.sel   = r_cnt[1:0];
            end
            S_M100: begin
                // fold 16-bit digits by their residues, then a reciprocal divide
                unique case (r_cnt[2:0])
                    3'd0: begin
                        o_unit_req.acc   = {48'b0, r_rng[15:0]};
                        o_unit_req.mul_a = RES_2P16;
                        o_unit_req.digit = r_rng[31:16];
                    end
                    3'd1: begin
                        o_unit_req.mul_a = RES_2P32;
                        o_unit_req.digit = r_rng[47:32];
                    end
                    3'd2: begin
                        o_unit_req.mul_a = RES_2P48;
                        o_unit_req.digit = r_rng[63:48];
                    end
                    3'd3: begin
                        o_unit_req.acc   = {48'b0, r_acc[15:0]};
                        o_unit_req.mul_a = RES_2P16;
                        o_unit_req.digit = {8'b0, r_acc[23:16]};
                    end
                    3'd4: begin
                        o_unit_req.acc   = {54'b0, r_acc[9:0]};
                        o_unit_req.mul_a = RES_2P10;
                        o_unit_req.digit = {9'b0, r_acc[16:10]};
                    end
                    3'd5: begin
                        o_unit_req.acc   = '0;
                        o_unit_req.mul_a = RCP_100;
                        o_unit_req.digit = r_acc[15:0];
                    end
                    3'd6: begin
                        o_unit_req.mul_a = NEG_100;
                        o_unit_req.digit = r_quo;
                    end
                    default: ;
                endcase
            end
            S_ADR0: begin
                o_unit_req.acc   = i_cfg.base_addr;
                o_unit_req.digit = r_page[15:0];
            end
            S_ADR1: begin
                o_unit_req.digit = {11'b0, r_page[20:16]};
                o_unit_req.sel   = 2'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_rng     <= RST_SEED_VALUE;
            r_idx     <= '0;
            r_cnt     <= '0;
            r_draw2   <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && o_acc.ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        if (i_req.restart) begin
                            r_rng <= i_cfg.seed_value;
                            r_idx <= '0;
                        end
                        r_state <= S_CHK0;
                    end
                end
                S_CHK0: begin
                    r_acc   <= i_unit_rsp.acc;
                    r_ovf   <= i_unit_rsp.carry;
                    r_state <= S_CHK1;
                end
                S_CHK1: begin
                    r_ovf   <= r_ovf | i_unit_rsp.carry;
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_bad   <= bad_cfg;
                    r_done  <= !bad_cfg && (r_idx >= i_cfg.run_length);
                    r_draw2 <= 1'b0;
                    r_rem   <= '0;
                    if (bad_cfg || (r_idx >= i_cfg.run_length)) begin
                        r_state <= S_OUT;
                    end else if (i_cfg.random_mode) begin
                        r_cnt   <= '0;
                        r_state <= S_LCG;
                    end else begin
                        // index is only 32 bits wide: 32 remainder steps
                        r_dvd   <= {r_idx, 32'b0};
                        r_cnt   <= 6'd31;
                        r_state <= S_DIV;
                    end
                end
                S_LCG: begin
                    r_acc <= i_unit_rsp.acc;
                    if (r_cnt[1:0] == 2'd3) begin
                        r_rng <= i_unit_rsp.acc;
                        if (r_draw2) begin
                            r_cnt   <= '0;
                            r_state <= S_M100;
                        end else begin
                            r_dvd   <= i_unit_rsp.acc;
                            r_rem   <= '0;
                            r_cnt   <= 6'd63;
                            r_state <= S_DIV;
                        end
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_DIV: begin
                    r_rem <= i_unit_rsp.rem;
                    r_dvd <= {r_dvd[62:0], 1'b0};
                    if (r_cnt == 6'd0) begin
                        r_page  <= i_unit_rsp.rem[20:0];
                        r_draw2 <= 1'b1;
                        r_cnt   <= '0;
                        r_state <= S_LCG;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                S_M100: begin
                    if (r_cnt == M100_QUO) begin
                        r_quo <= i_unit_rsp.acc[RCP_SHIFT +: 16];
                    end else begin
                        r_acc <= i_unit_rsp.acc;
                    end
                    if (r_cnt == M100_LAST) begin
                        r_wr    <= i_unit_rsp.acc[6:0] < i_cfg.write_percent;
                        r_state <= S_ADR0;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_ADR0: begin
                    r_acc   <= i_unit_rsp.acc;
                    r_state <= S_ADR1;
                end
                S_ADR1: begin
                    r_acc   <= i_unit_rsp.acc;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_o_num   <= r_idx;
                        r_o_err   <= r_bad;
                        r_o_done  <= r_done;
                        if (normal) begin
                            r_o_write <= r_wr;
                            r_o_addr  <= r_acc;
                            r_o_last  <= r_idx == (i_cfg.run_length - 32'd1);
                            r_idx     <= r_idx + 32'd1;
                        end else begin
                            r_o_write <= 1'b0;
                            r_o_addr  <= '0;
                            r_o_last  <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_acc.valid          = r_out_vld;
    assign o_acc.is_write       = r_o_write;
    assign o_acc.access_address = r_o_addr;
    assign o_acc.access_number  = r_o_num;
    assign o_acc.last           = r_o_last;
    assign o_acc.done_res       = r_o_done;
    assign o_acc.config_error   = r_o_err;

endmodule

@@ rtl/page_access_trace_generator_top.sv @@
// top level of the page access trace generator
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+-------------------------------------------
//  i_req    | in  | valid/ready       | restart
//  o_acc    | out | valid/ready       | is_write, access_address, access_number,
//           |     |                   | last, done_res, config_error
//  apb      | in  | psel/penable      | paddr, pwdata, prdata (64-bit registers)
//
// one request transfer at a time; ready is high only while the sequencer is idle
// range check, one-bit remainder steps for the page (32 in sequential page order,
// 64 in random order after a first lcg draw), four lcg multiply steps per draw,
// seven fold steps for the write pick, address; an unusable config or exhausted
// run skips to the result register; the next request is taken once it is loaded
// a full result register stalls the sequencer at its last step until the transfer
// synchronous active-low reset restores the register defaults, rng state 1, index 0
module page_access_trace_generator_top #(
    parameter int PAGE_BYTES      = 4096,
    parameter int PAGE_COUNT_BITS = 20
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    pat_req_if.sink                        i_req,
    pat_acc_if.source                      o_acc,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pat_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pat_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pat_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import pat_pkg::*;

    // configuration as seen by the sequencer
    t_cfg      cfg;
    // operands and results of the shared arithmetic unit
    t_unit_req unit_req;
    t_unit_rsp unit_rsp;

    // register file, written during apb access phase
    pat_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // multiply-accumulate for lcg, range check, address and modulo-100 fold;
    // remainder steps for the page
    pat_unit u_unit (
        .i_req (unit_req),
        .o_rsp (unit_rsp)
    );

    // control sequence and result register
    pat_seq #(
        .PAGE_BYTES      (PAGE_BYTES),
        .PAGE_COUNT_BITS (PAGE_COUNT_BITS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .o_unit_req (unit_req),
        .i_unit_rsp (unit_rsp),
        .i_req      (i_req),
        .o_acc      (o_acc)
    );

endmodule
